// ----- sv/bce_pkg.sv -----
`default_nettype none

package bce_pkg;

    localparam int C_NUM_SEGMENTS = 40;
    localparam int C_MAX_POINTS   = 16;
    localparam int C_IDX_W        = 6;
    localparam int C_ACC_W        = 68;

    typedef logic [30:0] t_weight;

    // Divide a Q?.30 blend sum by 2^30, round half up, saturate to 32 bits.
    function automatic logic [31:0] f_round_sat(input logic signed [C_ACC_W-1:0] a);
        logic signed [C_ACC_W-1:0] s;
        logic signed [C_ACC_W-31:0] q;
        s = a + C_ACC_W'(64'sd1 <<< 29);
        q = s[C_ACC_W-1:30];
        if (q > $signed((C_ACC_W-30)'(32'h7FFF_FFFF))) begin
            return 32'h7FFF_FFFF;
        end else if (q < -$signed((C_ACC_W-30)'(33'h0_8000_0000))) begin
            return 32'h8000_0000;
        end else begin
            return q[31:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/bezier_curve_evaluator.sv -----
// A point without the last flag is stored, or sets the drop flag when the store is full, and
// the block stays idle. A last point starts a curve of NUM_SEGMENTS+1 words; each end sample
// is copied from the store and each inner sample is blended by the single shared multiplier.
// One curve at a time; busy stays high until the final word, and falls as it is strobed.
// Words are strobed for one cycle on o_valid; the receiver cannot stall.
// Reset (synchronous, active low) empties the point store and clears the drop flag.
`default_nettype none

module bezier_curve_evaluator
    import bce_pkg::*;
#(
    parameter int NUM_SEGMENTS = C_NUM_SEGMENTS,
    parameter int MAX_POINTS   = C_MAX_POINTS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    output logic                            o_busy,
    input  wire logic signed [31:0]         i_ctrl_x,
    input  wire logic signed [31:0]         i_ctrl_y,
    input  wire logic signed [31:0]         i_ctrl_z,
    input  wire logic                       i_last_point,
    output logic                            o_valid,
    output logic signed [31:0]              o_curve_x,
    output logic signed [31:0]              o_curve_y,
    output logic signed [31:0]              o_curve_z,
    output logic [C_IDX_W-1:0]              o_sample_index,
    output logic                            o_last_sample,
    output logic                            o_overflow
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] C_MAXP = CW'(MAX_POINTS);
    localparam logic [C_IDX_W-1:0] C_LAST_I = C_IDX_W'(NUM_SEGMENTS);
    localparam logic [32:0] C_TQ_STEP = 33'((64'd1 << 32) / NUM_SEGMENTS);
    localparam logic [6:0]  C_REM_STEP = 7'((64'd1 << 32) % NUM_SEGMENTS);
    localparam logic [6:0]  C_REM_INIT = 7'(NUM_SEGMENTS / 2);
    localparam logic [6:0]  C_NSEG = 7'(NUM_SEGMENTS);
    localparam t_weight     C_WONE = t_weight'(32'd1 << 30);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SAMP = 4'd1;
    localparam logic [3:0] S_EPR  = 4'd2;
    localparam logic [3:0] S_EPO  = 4'd3;
    localparam logic [3:0] S_W1   = 4'd4;
    localparam logic [3:0] S_W2   = 4'd5;
    localparam logic [3:0] S_W3   = 4'd6;
    localparam logic [3:0] S_RD   = 4'd7;
    localparam logic [3:0] S_MX   = 4'd8;
    localparam logic [3:0] S_MY   = 4'd9;
    localparam logic [3:0] S_MZ   = 4'd10;
    localparam logic [3:0] S_AZ   = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [31:0] mem_x [MAX_POINTS];
    logic [31:0] mem_y [MAX_POINTS];
    logic [31:0] mem_z [MAX_POINTS];
    t_weight     r_b   [MAX_POINTS];

    logic [3:0]          r_state;
    logic [CW-1:0]       r_count;
    logic                r_drop;
    logic [C_IDX_W-1:0]  r_i;
    logic [32:0]         r_tq;
    logic [6:0]          r_rem;
    logic [AW-1:0]       r_j;
    logic [AW-1:0]       r_m;
    t_weight             r_hold;
    logic [31:0]         r_rd_x, r_rd_y, r_rd_z;
    logic signed [65:0]  r_prod;
    logic signed [C_ACC_W-1:0] r_acc_x, r_acc_y, r_acc_z;

    logic                accept;
    logic                mem_we;
    logic [AW-1:0]       b_addr;
    t_weight             b_rd;
    t_weight             b_prev;
    logic [31:0]         tq_lo;
    logic [31:0]         u_lo;
    logic signed [32:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic [63:0]         w_sum;
    logic [6:0]          rem_sum;
    logic                rem_wrap;
    logic                emit;

    assign accept  = i_start && (r_state == S_IDLE);
    assign mem_we  = accept && (r_count < C_MAXP);
    assign o_busy  = (r_state != S_IDLE);
    assign tq_lo   = r_tq[31:0];
    assign u_lo    = 32'(33'h1_0000_0000 - r_tq);
    assign emit    = (r_state == S_EPO) || (r_state == S_OUT);

    // During the weight pass the old b[j-1] is read; during the blend, b[j].
    assign b_addr  = (r_state == S_W2) ? (r_j - AW'(1)) : r_j;
    assign b_rd    = r_b[b_addr];
    assign b_prev  = (r_j == '0) ? '0 : b_rd;
    assign w_sum   = 64'(r_acc_x) + r_prod[63:0];
    assign rem_sum = r_rem + C_REM_STEP;
    assign rem_wrap = (rem_sum >= C_NSEG);

    always_comb begin
        mul_a = $signed({1'b0, u_lo});
        mul_b = $signed({2'b00, r_hold});
        unique case (r_state)
            S_W2: begin
                mul_a = $signed({1'b0, tq_lo});
                mul_b = $signed({2'b00, b_prev});
            end
            S_MX: begin
                mul_a = $signed({r_rd_x[31], r_rd_x});
                mul_b = $signed({2'b00, b_rd});
            end
            S_MY: begin
                mul_a = $signed({r_rd_y[31], r_rd_y});
                mul_b = $signed({2'b00, b_rd});
            end
            S_MZ: begin
                mul_a = $signed({r_rd_z[31], r_rd_z});
                mul_b = $signed({2'b00, b_rd});
            end
            default: begin
                mul_a = $signed({1'b0, u_lo});
                mul_b = $signed({2'b00, r_hold});
            end
        endcase
    end

    // Point store: one write port at the fill count, one registered read port at r_j.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_x[r_count[AW-1:0]] <= i_ctrl_x;
            mem_y[r_count[AW-1:0]] <= i_ctrl_y;
            mem_z[r_count[AW-1:0]] <= i_ctrl_z;
        end
        r_rd_x <= mem_x[r_j];
        r_rd_y <= mem_y[r_j];
        r_rd_z <= mem_z[r_j];
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            S_SAMP: begin
                r_b[0] <= C_WONE;
                r_hold <= '0;
            end
            S_W2: begin
                r_acc_x <= C_ACC_W'(r_prod) + C_ACC_W'(64'd1 << 31);
                r_hold  <= b_prev;
            end
            S_W3: begin
                r_b[r_j] <= w_sum[62:32];
                if (r_j == '0) begin
                    r_hold <= '0;
                end
            end
            S_RD: begin
                if (r_j == '0) begin
                    r_acc_x <= '0;
                    r_acc_y <= '0;
                    r_acc_z <= '0;
                end
            end
            S_MY: r_acc_x <= r_acc_x + C_ACC_W'(r_prod);
            S_MZ: r_acc_y <= r_acc_y + C_ACC_W'(r_prod);
            S_AZ: r_acc_z <= r_acc_z + C_ACC_W'(r_prod);
            default: begin
            end
        endcase
        if (r_state == S_EPO) begin
            o_curve_x <= r_rd_x;
            o_curve_y <= r_rd_y;
            o_curve_z <= r_rd_z;
        end else if (r_state == S_OUT) begin
            o_curve_x <= f_round_sat(r_acc_x);
            o_curve_y <= f_round_sat(r_acc_y);
            o_curve_z <= f_round_sat(r_acc_z);
        end
        if (emit) begin
            o_sample_index <= r_i;
            o_last_sample  <= (r_i == C_LAST_I);
            o_overflow     <= r_drop;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_i     <= '0;
            r_tq    <= '0;
            r_rem   <= C_REM_INIT;
            r_j     <= '0;
            r_m     <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= emit;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (r_count < C_MAXP) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_last_point) begin
                            r_i     <= '0;
                            r_tq    <= '0;
                            r_rem   <= C_REM_INIT;
                            r_state <= S_SAMP;
                        end
                    end
                end
                S_SAMP: begin
                    if (r_i == '0) begin
                        r_j     <= '0;
                        r_state <= S_EPR;
                    end else if (r_i == C_LAST_I) begin
                        r_j     <= AW'(r_count - CW'(1));
                        r_state <= S_EPR;
                    end else if (r_count == CW'(1)) begin
                        r_j     <= '0;
                        r_state <= S_RD;
                    end else begin
                        r_m     <= AW'(1);
                        r_j     <= AW'(1);
                        r_state <= S_W1;
                    end
                end
                S_EPR: r_state <= S_EPO;
                S_W1:  r_state <= S_W2;
                S_W2:  r_state <= S_W3;
                S_W3: begin
                    if (r_j != '0) begin
                        r_j     <= r_j - AW'(1);
                        r_state <= S_W1;
                    end else if (CW'(r_m) + CW'(1) == r_count) begin
                        r_state <= S_RD;
                    end else begin
                        r_m     <= r_m + AW'(1);
                        r_j     <= r_m + AW'(1);
                        r_state <= S_W1;
                    end
                end
                S_RD: r_state <= S_MX;
                S_MX: r_state <= S_MY;
                S_MY: r_state <= S_MZ;
                S_MZ: r_state <= S_AZ;
                S_AZ: begin
                    if (CW'(r_j) + CW'(1) == r_count) begin
                        r_state <= S_OUT;
                    end else begin
                        r_j     <= r_j + AW'(1);
                        r_state <= S_RD;
                    end
                end
                S_EPO, S_OUT: begin
                    // Step t by 1/NUM_SEGMENTS, keeping the rounded quotient exact.
                    r_i   <= r_i + C_IDX_W'(1);
                    r_tq  <= r_tq + C_TQ_STEP + 33'(rem_wrap);
                    r_rem <= rem_wrap ? (rem_sum - C_NSEG) : rem_sum;
                    if (r_i == C_LAST_I) begin
                        r_count <= '0;
                        r_drop  <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_SAMP;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_last_point |=> o_busy)
        else $error("last point did not start a curve");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_sample |-> o_busy)
        else $error("curve ended before its final word");

    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_sample |-> !o_busy)
        else $error("still busy after the final word");

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two words on consecutive cycles");

endmodule

`default_nettype wire

// ----- verif/tb_bezier_curve_evaluator.sv -----
`default_nettype none

module tb_bezier_curve_evaluator;
    import bce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES   = 700;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
    } t_point;

    typedef struct {
        logic signed [31:0]   x;
        logic signed [31:0]   y;
        logic signed [31:0]   z;
        logic [C_IDX_W-1:0]   idx;
        logic                 last;
        logic                 ovf;
    } t_sample;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_start;
    logic                     o_busy;
    logic signed [31:0]       i_ctrl_x;
    logic signed [31:0]       i_ctrl_y;
    logic signed [31:0]       i_ctrl_z;
    logic                     i_last_point;
    logic                     o_valid;
    logic signed [31:0]       o_curve_x;
    logic signed [31:0]       o_curve_y;
    logic signed [31:0]       o_curve_z;
    logic [C_IDX_W-1:0]       o_sample_index;
    logic                     o_last_sample;
    logic                     o_overflow;

    bezier_curve_evaluator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_ctrl_x       (i_ctrl_x),
        .i_ctrl_y       (i_ctrl_y),
        .i_ctrl_z       (i_ctrl_z),
        .i_last_point   (i_last_point),
        .o_valid        (o_valid),
        .o_curve_x      (o_curve_x),
        .o_curve_y      (o_curve_y),
        .o_curve_z      (o_curve_z),
        .o_sample_index (o_sample_index),
        .o_last_sample  (o_last_sample),
        .o_overflow     (o_overflow)
    );

    t_point  pending_points[$];
    t_sample expected_samples[$];
    t_point  cur_point;

    logic signed [31:0] store_x[C_MAX_POINTS];
    logic signed [31:0] store_y[C_MAX_POINTS];
    logic signed [31:0] store_z[C_MAX_POINTS];
    int unsigned stored_cnt;
    logic        dropped;

    int unsigned total_points;
    int unsigned sent_points;
    int unsigned curve_cnt;
    int unsigned drop_cnt;
    int unsigned sample_cnt;
    int unsigned error_cnt;
    int unsigned quiet_cycles;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Bernstein weights in Q2.30 by degree raising, rounded half up at bit 32.
    function automatic void bernstein(input int i, input int n, output logic [63:0] w[C_MAX_POINTS]);
        logic [63:0] tq;
        logic [63:0] uq;
        tq = ((64'(i) << 32) + 64'(C_NUM_SEGMENTS / 2)) / 64'(C_NUM_SEGMENTS);
        uq = (64'd1 << 32) - tq;
        for (int k = 0; k < C_MAX_POINTS; k++) w[k] = '0;
        w[0] = 64'd1 << 30;
        for (int m = 1; m < n; m++) begin
            w[m] = (tq * w[m-1] + (64'd1 << 31)) >> 32;
            for (int j = m - 1; j >= 1; j--) begin
                w[j] = (uq * w[j] + tq * w[j-1] + (64'd1 << 31)) >> 32;
            end
            w[0] = (uq * w[0] + (64'd1 << 31)) >> 32;
        end
    endfunction

    function automatic logic signed [31:0] blend_axis(input logic signed [31:0] p[C_MAX_POINTS],
                                                     input logic [63:0] w[C_MAX_POINTS],
                                                     input int n);
        logic signed [95:0] acc;
        logic signed [95:0] r;
        acc = '0;
        for (int j = 0; j < n; j++) begin
            acc = acc + ($signed(p[j]) * $signed({1'b0, w[j]}));
        end
        r = (acc + (96'sd1 <<< 29)) >>> 30;
        if (r > 96'sd2147483647) return 32'h7FFF_FFFF;
        if (r < -96'sd2147483648) return 32'h8000_0000;
        return r[31:0];
    endfunction

    function automatic void emit_curve();
        logic [63:0] w[C_MAX_POINTS];
        t_sample s;
        int n;
        n = stored_cnt;
        for (int i = 0; i <= C_NUM_SEGMENTS; i++) begin
            if (i == 0) begin
                s.x = store_x[0];
                s.y = store_y[0];
                s.z = store_z[0];
            end else if (i == C_NUM_SEGMENTS) begin
                s.x = store_x[n-1];
                s.y = store_y[n-1];
                s.z = store_z[n-1];
            end else begin
                bernstein(i, n, w);
                s.x = blend_axis(store_x, w, n);
                s.y = blend_axis(store_y, w, n);
                s.z = blend_axis(store_z, w, n);
            end
            s.idx  = C_IDX_W'(i);
            s.last = (i == C_NUM_SEGMENTS);
            s.ovf  = dropped;
            expected_samples = {expected_samples, s};
        end
        stored_cnt = 0;
        dropped    = 1'b0;
        curve_cnt++;
    endfunction

    function automatic void absorb_point(input t_point p);
        if (stored_cnt < C_MAX_POINTS) begin
            store_x[stored_cnt] = p.x;
            store_y[stored_cnt] = p.y;
            store_z[stored_cnt] = p.z;
            stored_cnt++;
        end else begin
            dropped = 1'b1;
            drop_cnt++;
        end
        if (p.last) emit_curve();
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $signed(32'($urandom_range(2000))) - 1000;
            3, 4: return $signed({{8{1'b0}}, 24'($urandom)}) - 32'sh0080_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_point(input logic signed [31:0] x, input logic signed [31:0] y,
                                      input logic signed [31:0] z, input logic last);
        t_point p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.last = last;
        pending_points = {pending_points, p};
    endfunction

    // Stall ratio follows the share of points already sent.
    function automatic int idle_pct();
        case ((sent_points * 4) / (total_points + 1))
            1: return 55;
            3: return 16;
            default: return 0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        logic taken;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            taken = i_start && !o_busy;
            if (taken) begin
                absorb_point(cur_point);
                sent_points++;
            end
            if (!i_start || taken) begin
                if (pending_points.size() > 0 && $urandom_range(99) >= idle_pct()) begin
                    cur_point = pending_points.pop_front();
                    i_ctrl_x     <= cur_point.x;
                    i_ctrl_y     <= cur_point.y;
                    i_ctrl_z     <= cur_point.z;
                    i_last_point <= cur_point.last;
                    i_start      <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_sample e;
        if (i_rst_n && o_valid) begin
            sample_cnt++;
            if (expected_samples.size() == 0) begin
                $error("unexpected word: index %0d x %0d", o_sample_index, o_curve_x);
                error_cnt++;
            end else begin
                e = expected_samples.pop_front();
                if (o_curve_x !== e.x) begin
                    $error("curve_x: expected %0d, got %0d", e.x, o_curve_x);
                    error_cnt++;
                end
                if (o_curve_y !== e.y) begin
                    $error("curve_y: expected %0d, got %0d", e.y, o_curve_y);
                    error_cnt++;
                end
                if (o_curve_z !== e.z) begin
                    $error("curve_z: expected %0d, got %0d", e.z, o_curve_z);
                    error_cnt++;
                end
                if (o_sample_index !== e.idx) begin
                    $error("sample_index: expected %0d, got %0d", e.idx, o_sample_index);
                    error_cnt++;
                end
                if (o_last_sample !== e.last) begin
                    $error("last_sample: expected %0b, got %0b", e.last, o_last_sample);
                    error_cnt++;
                end
                if (o_overflow !== e.ovf) begin
                    $error("overflow: expected %0b, got %0b", e.ovf, o_overflow);
                    error_cnt++;
                end
            end
        end
        if (!i_rst_n || o_valid || (i_start && !o_busy)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d words outstanding", expected_samples.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        int len;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_ctrl_x     = '0;
        i_ctrl_y     = '0;
        i_ctrl_z     = '0;
        i_last_point = 1'b0;
        stored_cnt   = 0;
        dropped      = 1'b0;
        sent_points  = 0;
        curve_cnt    = 0;
        drop_cnt     = 0;
        sample_cnt   = 0;
        error_cnt    = 0;
        quiet_cycles = 0;

        // A lone point, then two points at opposite extremes, then a short curve.
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b1);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b1);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        // Store overflow: the final point is dropped yet still closes the curve.
        for (int k = 0; k < C_MAX_POINTS + 2; k++) begin
            add_point(rand_coord(), rand_coord(), rand_coord(), k == C_MAX_POINTS + 1);
        end
        while (pending_points.size() < 320) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(C_MAX_POINTS + 4, 12)
                                          : $urandom_range(6, 1);
            for (int k = 0; k < len; k++) begin
                add_point(rand_coord(), rand_coord(), rand_coord(), k == len - 1);
            end
        end
        total_points = pending_points.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_points.size() > 0 || i_start || expected_samples.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d control points in %0d curves, %0d points past a full store, %0d words",
                 sent_points, curve_cnt, drop_cnt, sample_cnt);
        if (error_cnt == 0 && expected_samples.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
